@@ src/sorted_priority_queue_unit_defines.svh @@
// Assertion macros for the sorted priority queue unit.
// Used by the top level only; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Whenever cond holds on a clock edge, expr must hold on the same edge.
`define SPQ_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("sorted priority queue check failed");

// Whenever cond holds on a clock edge, expr must hold on the next edge.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("sorted priority queue check failed");

`else

`define SPQ_ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define SPQ_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

@@ src/spq_pkg.sv @@
// Package for the sorted priority queue unit: sizes, codes and beat types.
// Used by spq_ctrl, spq_dp and sorted_priority_queue_unit; no dependencies.
`default_nettype none

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int PRI_W    = 8;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PUSH,
    ACT_POP
  } action_t;

  typedef struct packed {
    logic                    op;
    logic signed [VAL_W-1:0] item_value;
    logic        [PRI_W-1:0] item_priority;
  } in_beat_t;

  typedef struct packed {
    logic        [1:0]       status;
    logic signed [VAL_W-1:0] popped_value;
    logic        [PRI_W-1:0] popped_priority;
    logic                    is_empty;
    logic        [CNT_W-1:0] entry_count;
  } out_beat_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load;
    logic       exec;
    action_t    action;
    logic [1:0] code;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic op_pop;
    logic empty;
    logic full;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ src/spq_ctrl.sv @@
// Controller of the sorted priority queue unit: sequences load and update.
// Depends on spq_pkg.
`default_nettype none

module spq_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  input  spq_pkg::dp_sts_t     sts,
  output spq_pkg::dp_cmd_t     cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_exec;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign can_exec  = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    cmd.load   = in_valid && (state_r == S_IDLE);
    cmd.exec   = can_exec;
    cmd.action = spq_pkg::ACT_NONE;
    cmd.code   = spq_pkg::ST_DONE;
    if (sts.op_pop) begin
      if (sts.empty) begin
        cmd.code = spq_pkg::ST_EMPTY;
      end else begin
        cmd.action = spq_pkg::ACT_POP;
      end
    end else begin
      if (sts.full) begin
        cmd.code = spq_pkg::ST_FULL;
      end else begin
        cmd.action = spq_pkg::ACT_PUSH;
      end
    end

    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (can_exec) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/spq_dp.sv @@
// Datapath of the sorted priority queue unit: slot registers, parallel
// priority compare, shift-insert and shift-remove, result register.
// Depends on spq_pkg.
`default_nettype none

module spq_dp (
  input  wire                  clk,
  input  wire                  rst_n,
  input  spq_pkg::in_beat_t    in_data,
  input  spq_pkg::dp_cmd_t     cmd,
  output spq_pkg::dp_sts_t     sts,
  output spq_pkg::out_beat_t   out_data
);

  localparam int N = spq_pkg::CAPACITY;

  logic signed [spq_pkg::VAL_W-1:0] slot_val_r [N];
  logic        [spq_pkg::PRI_W-1:0] slot_pri_r [N];
  logic signed [spq_pkg::VAL_W-1:0] slot_val_nxt [N];
  logic        [spq_pkg::PRI_W-1:0] slot_pri_nxt [N];
  logic        [spq_pkg::CNT_W-1:0] occ_r, occ_nxt;

  logic                             op_r;
  logic signed [spq_pkg::VAL_W-1:0] val_r;
  logic        [spq_pkg::PRI_W-1:0] pri_r;
  logic        [N-1:0]              ge_r, ge_nxt;

  logic [N-1:0] tail_mask;
  logic [N-1:0] hit;
  logic [N-1:0] ins_onehot;
  logic [N-1:0] at_or_after;
  logic [N-1:0] shift_up;

  spq_pkg::out_beat_t out_r, out_nxt;

  assign sts.op_pop = (op_r == spq_pkg::OP_POP);
  assign sts.empty  = (occ_r == '0);
  assign sts.full   = (occ_r == spq_pkg::CNT_W'(N));
  assign out_data   = out_r;

  // The head breaks ties differently: a new entry goes ahead of it only on a
  // strictly greater head priority, while later slots yield on equal ones.
  always_comb begin
    for (int j = 0; j < N; j++) begin
      if (j == 0) begin
        ge_nxt[j] = slot_pri_r[j] > in_data.item_priority;
      end else begin
        ge_nxt[j] = slot_pri_r[j] >= in_data.item_priority;
      end
    end
  end

  // Unoccupied slots count as hits, so the tail is the fallback position.
  // The lowest hit marks the insertion slot; everything above it moves up.
  always_comb begin
    for (int j = 0; j < N; j++) begin
      tail_mask[j] = spq_pkg::CNT_W'(j) >= occ_r;
    end
    hit         = (ge_r & ~tail_mask) | tail_mask;
    ins_onehot  = hit & (~hit + N'(1));
    at_or_after = ~(ins_onehot - N'(1));
    shift_up    = at_or_after & ~ins_onehot;
  end

  always_comb begin
    for (int j = 0; j < N; j++) begin
      slot_val_nxt[j] = slot_val_r[j];
      slot_pri_nxt[j] = slot_pri_r[j];
      case (cmd.action)
        spq_pkg::ACT_PUSH: begin
          if (ins_onehot[j]) begin
            slot_val_nxt[j] = val_r;
            slot_pri_nxt[j] = pri_r;
          end else if (shift_up[j] && j > 0) begin
            slot_val_nxt[j] = slot_val_r[(j > 0) ? j - 1 : 0];
            slot_pri_nxt[j] = slot_pri_r[(j > 0) ? j - 1 : 0];
          end
        end
        spq_pkg::ACT_POP: begin
          if (j < N - 1) begin
            slot_val_nxt[j] = slot_val_r[(j < N - 1) ? j + 1 : j];
            slot_pri_nxt[j] = slot_pri_r[(j < N - 1) ? j + 1 : j];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    case (cmd.action)
      spq_pkg::ACT_PUSH: occ_nxt = occ_r + spq_pkg::CNT_W'(1);
      spq_pkg::ACT_POP:  occ_nxt = occ_r - spq_pkg::CNT_W'(1);
      default:           occ_nxt = occ_r;
    endcase

    out_nxt.status          = cmd.code;
    out_nxt.popped_value    = '0;
    out_nxt.popped_priority = '0;
    if (cmd.action == spq_pkg::ACT_POP) begin
      out_nxt.popped_value    = slot_val_r[0];
      out_nxt.popped_priority = slot_pri_r[0];
    end
    out_nxt.is_empty    = (occ_nxt == '0);
    out_nxt.entry_count = occ_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (cmd.exec) begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_data.op;
      val_r <= in_data.item_value;
      pri_r <= in_data.item_priority;
      ge_r  <= ge_nxt;
    end
    if (cmd.exec) begin
      out_r <= out_nxt;
      for (int j = 0; j < N; j++) begin
        slot_val_r[j] <= slot_val_nxt[j];
        slot_pri_r[j] <= slot_pri_nxt[j];
      end
    end
  end

endmodule

`default_nettype wire

@@ src/sorted_priority_queue_unit.sv @@
// Channel  Direction  Beat type             Handshake
// in_      input      spq_pkg::in_beat_t    in_valid / in_ready
// out_     output     spq_pkg::out_beat_t   out_valid / out_ready
//
// Each operation has a load step and an execute step: the load step registers
// the beat together with sixteen parallel priority compares against the slots,
// the execute step shifts the slot row and loads the result register. A waiting
// result holds the execute step until out_ready frees the result register. Reset
// (rst_n, synchronous) empties the queue at once; slot contents are not cleared.
// Depends on spq_pkg, spq_ctrl, spq_dp and sorted_priority_queue_unit_defines.svh.
`default_nettype none

`include "sorted_priority_queue_unit_defines.svh"

module sorted_priority_queue_unit (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  spq_pkg::in_beat_t    in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output spq_pkg::out_beat_t   out_data
);

  spq_pkg::dp_cmd_t cmd;
  spq_pkg::dp_sts_t sts;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  spq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  // The count never runs past the capacity, and the empty flag tracks it.
  `SPQ_ASSERT_IMPLIES(a_count_bound, clk, rst_n, out_valid, out_data.entry_count <= spq_pkg::CNT_W'(spq_pkg::CAPACITY))
  `SPQ_ASSERT_IMPLIES(a_empty_flag, clk, rst_n, out_valid, out_data.is_empty == (out_data.entry_count == '0))
  // Only a successful pop carries data.
  `SPQ_ASSERT_IMPLIES(a_fail_no_data, clk, rst_n, out_valid && (out_data.status != spq_pkg::ST_DONE), (out_data.popped_value == '0) && (out_data.popped_priority == '0))
  // One operation at a time: an accepted beat keeps the input closed next cycle.
  `SPQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire
